// ----- src/ipsf_pkg.sv -----
package ipsf_pkg;

	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 24;
	localparam int LIMIT_W  = 15;
	localparam int ERR_W    = SAMPLE_W + 1;
	localparam int ACC_W    = 32;
	localparam int FBK_W    = GAIN_W;
	localparam int FRAC_W   = 16;

	localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST = '1;

	typedef enum logic [1:0] {
		REG_PROP_GAIN   = 2'd0,
		REG_INTEG_GAIN  = 2'd1,
		REG_FBK_GAIN    = 2'd2,
		REG_DRIVE_LIMIT = 2'd3
	} cfg_reg_t;

	// loop state carried from one sample to the next
	typedef struct packed {
		logic signed [ERR_W-1:0] error_prev;
		logic signed [ACC_W-1:0] integrated_prev;
		logic signed [FBK_W-1:0] feedback_prev;
	} loop_state_t;

	function automatic logic signed [ACC_W-1:0] sat32(input logic signed [ACC_W:0] v);
		logic signed [ACC_W-1:0] r;
		if (v[ACC_W] != v[ACC_W-1])
			r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		else
			r = v[ACC_W-1:0];
		return r;
	endfunction

endpackage

// ----- src/ipsf_core.sv -----
module ipsf_core (
	input  logic signed [ipsf_pkg::SAMPLE_W-1:0] setpoint,
	input  logic signed [ipsf_pkg::SAMPLE_W-1:0] measured,
	input  logic [ipsf_pkg::GAIN_W-1:0]          prop_gain,
	input  logic [ipsf_pkg::GAIN_W-1:0]          integ_gain,
	input  logic signed [ipsf_pkg::GAIN_W-1:0]   fbk_gain,
	input  logic [ipsf_pkg::LIMIT_W-1:0]         drive_limit,
	input  ipsf_pkg::loop_state_t                st,
	output ipsf_pkg::loop_state_t                st_next,
	output logic signed [ipsf_pkg::SAMPLE_W-1:0] drive,
	output logic                                 clamped
);

	localparam int EW = ipsf_pkg::ERR_W;
	localparam int DW = EW + 1;
	localparam int GW = ipsf_pkg::GAIN_W;
	localparam int AW = ipsf_pkg::ACC_W;
	localparam int FW = ipsf_pkg::FRAC_W;
	localparam int SW = ipsf_pkg::SAMPLE_W;
	localparam int PW = GW + 1 + DW;
	localparam int IW = GW + 1 + EW;
	localparam int QW = GW + SW;
	localparam int BW = ipsf_pkg::FBK_W + 2;

	logic signed [EW-1:0]   err;
	logic signed [DW-1:0]   derr;
	logic signed [PW-1:0]   pprod;
	logic signed [IW-1:0]   iprod;
	logic signed [QW-1:0]   fprod;
	logic signed [PW-FW-1:0] pterm;
	logic signed [IW-FW-1:0] iterm;
	logic signed [AW-1:0]   sum1;
	logic signed [AW-1:0]   u_raw;
	logic signed [BW-1:0]   hi;
	logic signed [BW-1:0]   lo;
	logic signed [AW-1:0]   u_clip;
	logic signed [QW-FW-1:0] fb;
	logic signed [AW:0]     diff;
	logic signed [AW:0]     lim_pos;
	logic signed [AW:0]     lim_neg;

	assign err  = {setpoint[SW-1], setpoint} - {measured[SW-1], measured};
	assign derr = {err[EW-1], err} - {st.error_prev[EW-1], st.error_prev};

	assign pprod = $signed({1'b0, prop_gain}) * derr;
	assign iprod = $signed({1'b0, integ_gain}) * err;
	assign fprod = fbk_gain * measured;

	// arithmetic shift by dropping fraction bits: floor rounding
	assign pterm = pprod[PW-1:FW];
	assign iterm = iprod[IW-1:FW];
	assign fb    = fprod[QW-1:FW];

	assign sum1  = ipsf_pkg::sat32({st.integrated_prev[AW-1], st.integrated_prev}
		+ (AW+1)'(pterm));
	assign u_raw = ipsf_pkg::sat32({sum1[AW-1], sum1} + (AW+1)'(iterm));

	// window around the previous feedback term; cannot overflow 32 bits
	assign hi = BW'(st.feedback_prev) + BW'({1'b0, drive_limit});
	assign lo = BW'(st.feedback_prev) - BW'({1'b0, drive_limit});

	always_comb begin
		if (u_raw > AW'(hi))
			u_clip = AW'(hi);
		else if (u_raw < AW'(lo))
			u_clip = AW'(lo);
		else
			u_clip = u_raw;
	end

	assign diff    = {u_clip[AW-1], u_clip} - (AW+1)'(fb);
	assign lim_pos = (AW+1)'({1'b0, drive_limit});
	assign lim_neg = -lim_pos;

	always_comb begin
		clamped = 1'b1;
		if (diff > lim_pos)
			drive = SW'(lim_pos);
		else if (diff < lim_neg)
			drive = SW'(lim_neg);
		else begin
			drive   = diff[SW-1:0];
			clamped = 1'b0;
		end
	end

	assign st_next.error_prev      = err;
	assign st_next.integrated_prev = u_clip;
	assign st_next.feedback_prev   = fb;

endmodule

// ----- src/incremental_pi_state_feedback.sv -----
// Incremental PI controller with inner state feedback and a symmetric output clamp.
// One setpoint/measured pair goes in per transfer and one drive value comes out per
// transfer, in order. Throughput is one sample per clock unless the output stalls; output
// valid rises once the input register has captured the sample at the transfer and the
// result register has captured its result. The loop state (previous error, previous PI
// output, previous feedback term) updates in the same cycle the result is registered,
// so the combinational datapath from input register through the three multipliers and
// clamps to the state and result registers sets the clock rate. Gains written on the
// cfg port take effect on the next sample; write them only while no sample is in flight.
module incremental_pi_state_feedback (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] setpoint, [31:16] measured
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] drive
	output logic        m_tuser,   // [0] clamped
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [23:0] cfg_wdata
);

	localparam int SW = ipsf_pkg::SAMPLE_W;
	localparam int GW = ipsf_pkg::GAIN_W;
	localparam int LW = ipsf_pkg::LIMIT_W;

	logic [GW-1:0]          prop_gain_q;
	logic [GW-1:0]          integ_gain_q;
	logic signed [GW-1:0]   fbk_gain_q;
	logic [LW-1:0]          drive_limit_q;

	logic                   valid_s1;
	logic signed [SW-1:0]   setpoint_s1;
	logic signed [SW-1:0]   measured_s1;
	logic                   advance;

	ipsf_pkg::loop_state_t  state_q;
	ipsf_pkg::loop_state_t  state_next;
	logic signed [SW-1:0]   drive;
	logic                   clamped;

	logic                   valid_s2;
	logic [SW-1:0]          drive_s2;
	logic                   clamped_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q   <= '0;
			integ_gain_q  <= '0;
			fbk_gain_q    <= '0;
			drive_limit_q <= ipsf_pkg::DRIVE_LIMIT_RST;
		end else if (cfg_we) begin
			case (ipsf_pkg::cfg_reg_t'(cfg_addr))
				ipsf_pkg::REG_PROP_GAIN:   prop_gain_q   <= cfg_wdata[GW-1:0];
				ipsf_pkg::REG_INTEG_GAIN:  integ_gain_q  <= cfg_wdata[GW-1:0];
				ipsf_pkg::REG_FBK_GAIN:    fbk_gain_q    <= cfg_wdata[GW-1:0];
				ipsf_pkg::REG_DRIVE_LIMIT: drive_limit_q <= cfg_wdata[LW-1:0];
				default: ;
			endcase
		end
	end

	// result register free or being drained this cycle
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			setpoint_s1 <= s_tdata[SW-1:0];
			measured_s1 <= s_tdata[2*SW-1:SW];
		end
	end

	ipsf_core u_core (
		.setpoint    (setpoint_s1),
		.measured    (measured_s1),
		.prop_gain   (prop_gain_q),
		.integ_gain  (integ_gain_q),
		.fbk_gain    (fbk_gain_q),
		.drive_limit (drive_limit_q),
		.st          (state_q),
		.st_next     (state_next),
		.drive       (drive),
		.clamped     (clamped)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1)
				state_q <= state_next;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			drive_s2   <= drive;
			clamped_s2 <= clamped;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = drive_s2;
	assign m_tuser  = clamped_s2;

endmodule
